// ===== rtl/core/mcst_pkg.sv =====
// ============================================================================
// mcst_pkg
// Shared types and fixed field widths of the multi-cause survival tracker.
// ============================================================================
package mcst_pkg;

    localparam int AXIS_W     = 3;   // cause index field
    localparam int AMOUNT_W   = 24;  // count or level fraction field
    localparam int POP_W      = 24;  // population and removed count
    localparam int REF_W      = 24;  // reference population register
    localparam int AXES_CFG_W = 4;   // axes_in_use register

    // Register indexes on the configuration port (byte address 4*index)
    localparam logic REG_REF_POP = 1'b0;
    localparam logic REG_AXES    = 1'b1;

    // Request modes
    localparam logic MODE_REMOVE = 1'b0;
    localparam logic MODE_LEVEL  = 1'b1;

    typedef struct packed {
        logic                mode;
        logic [AXIS_W-1:0]   axis;
        logic [AMOUNT_W-1:0] amount;
        logic                last_level;
    } t_in_req;

    typedef struct packed {
        logic [POP_W-1:0] removed;
        logic [POP_W-1:0] population;
        logic             axis_error;
    } t_out_rsp;

endpackage

// ===== rtl/core/multi_cause_survival_tracker.sv =====
// ============================================================================
// multi_cause_survival_tracker
// Per-cause mortality fractions with a shared multiplier and a bit-serial
// divider under one sequencer.
// ============================================================================
// Usage:
//   Input channel (i_in_valid / o_in_ready, payload i_in_data) takes one request:
//   a remove (count charged against a cause) or a level (fraction compounded
//   into a cause). Output channel (o_out_valid / i_out_ready, o_out_data) gives
//   at most one result per request; a level request that is not the last of a
//   run and hits a valid axis gives none.
//   One request at a time; o_in_ready is high only when the sequencer is idle.
//   The time per request is set by the survival product, one cause per cycle
//   through the single multiplier, and, for a remove, the divider, one
//   quotient bit per cycle. The result sits in an output register; a new
//   request is accepted while it waits, and the sequencer only holds in its
//   final step if that register is still full. Reset clears all fractions
//   to zero, the reference population to 1 and axes_in_use to 1.
//   Configuration writes are to be made by the user only while the block is
//   idle; the block itself does not enforce this.
// ============================================================================
module multi_cause_survival_tracker #(
    parameter int MAX_AXES  = 8,
    parameter int FRAC_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  mcst_pkg::t_in_req    i_in_data,
    // result channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output mcst_pkg::t_out_rsp   o_out_data,
    // configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    // ------------------------------------------------------------------
    // Widths
    // ------------------------------------------------------------------
    localparam int FW   = FRAC_BITS + 1;                       // fraction / product
    localparam int MW   = (FW > mcst_pkg::REF_W) ? FW : mcst_pkg::REF_W; // mult operand
    localparam int SW   = mcst_pkg::REF_W + FW;                // ref * product
    localparam int NCW  = SW + 1 - FRAC_BITS;                  // rounded-up population
    localparam int CW   = $clog2(MAX_AXES + 1);                // cause counter
    localparam int IW   = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int DCW  = $clog2(FW);                          // divider step counter

    localparam logic [FW-1:0] ONE_FW   = {1'b1, {FRAC_BITS{1'b0}}};
    localparam logic [MW-1:0] ONE_MW   = MW'(ONE_FW);
    localparam logic [SW:0]   ROUND_UP = (SW+1)'({FRAC_BITS{1'b1}});

    // ------------------------------------------------------------------
    // Sequencer states
    // ------------------------------------------------------------------
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SOLD  = 4'd1;   // product over all causes, before update
    localparam logic [3:0] ST_OSC   = 4'd2;   // old scaled population
    localparam logic [3:0] ST_QPASS = 4'd3;   // product skipping the addressed cause
    localparam logic [3:0] ST_QSC   = 4'd4;   // cap = ref * Q
    localparam logic [3:0] ST_DINIT = 4'd5;   // clip the request to the cap
    localparam logic [3:0] ST_DIV   = 4'd6;   // one quotient bit per cycle
    localparam logic [3:0] ST_UPD   = 4'd7;   // saturating fraction update
    localparam logic [3:0] ST_SNEW  = 4'd8;   // product after update
    localparam logic [3:0] ST_NSC   = 4'd9;   // new scaled population
    localparam logic [3:0] ST_CEIL  = 4'd10;  // round population up
    localparam logic [3:0] ST_FIN   = 4'd11;  // load output register
    localparam logic [3:0] ST_LVL   = 4'd12;  // level compounding

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [3:0]                       r_state;
    logic [mcst_pkg::REF_W-1:0]       r_ref_cfg;
    logic [mcst_pkg::AXES_CFG_W-1:0]  r_axes_cfg;
    logic [FW-1:0]                    r_frac [MAX_AXES];

    mcst_pkg::t_in_req                r_req;
    logic [mcst_pkg::REF_W-1:0]       r_ref;
    logic [CW-1:0]                    r_nact;
    logic                             r_err;
    logic [CW-1:0]                    r_cnt;
    logic [FW-1:0]                    r_s;      // running survival product
    logic [SW-1:0]                    r_old;    // old unrounded population
    logic [SW-1:0]                    r_sc;     // population to round up
    logic [SW-1:0]                    r_cap;
    logic [SW:0]                      r_rem;
    logic [FW-1:0]                    r_q;
    logic [DCW-1:0]                   r_dcnt;
    logic [NCW-1:0]                   r_nc;

    logic                             r_out_valid;
    mcst_pkg::t_out_rsp               r_out;

    // ------------------------------------------------------------------
    // Config port: APB, always ready
    // ------------------------------------------------------------------
    logic cfg_wr;
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            mcst_pkg::REG_REF_POP: prdata = 32'(r_ref_cfg);
            mcst_pkg::REG_AXES:    prdata = 32'(r_axes_cfg);
            default:               prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic            in_acc;
    logic [CW-1:0]   nact_in;
    logic            err_in;
    logic            in_pass;
    logic [IW-1:0]   axis_idx;
    logic [IW-1:0]   rd_idx;
    logic [FW-1:0]   f_rd;
    logic [FW-1:0]   f_rest;
    logic            skip;
    logic            pass_done;
    logic [MW-1:0]   lvl;
    logic [MW-1:0]   mul_a;
    logic [MW-1:0]   mul_b;
    logic [2*MW-1:0] mul_p;
    logic [SW:0]     want;
    logic            div_bit;
    logic [SW:0]     rem_sub;
    logic [FW:0]     f_sum;
    logic [SW:0]     ceil_sum;
    logic [SW:0]     nc_scaled;
    logic [SW:0]     old_ext;
    logic [SW:0]     diff;
    logic            out_free;

    assign in_acc = i_in_valid && o_in_ready;

    // Effective cause count: values above MAX_AXES act as MAX_AXES
    assign nact_in = (32'(r_axes_cfg) > 32'(MAX_AXES)) ? CW'(MAX_AXES) : CW'(r_axes_cfg);
    assign err_in  = 32'(i_in_data.axis) >= 32'(nact_in);

    assign in_pass   = (r_state == ST_SOLD) || (r_state == ST_QPASS) || (r_state == ST_SNEW);
    assign axis_idx  = IW'(r_req.axis);
    assign rd_idx    = in_pass ? r_cnt[IW-1:0] : axis_idx;
    assign f_rd      = r_frac[rd_idx];
    assign f_rest    = ONE_FW - f_rd;
    assign skip      = (r_state == ST_QPASS) && (32'(r_cnt) == 32'(r_req.axis));
    assign pass_done = (r_cnt == r_nact);

    // Level fraction saturates at 1.0
    assign lvl = (MW'(r_req.amount) > ONE_MW) ? ONE_MW : MW'(r_req.amount);

    // Shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (in_pass) begin
            mul_a = MW'(r_s);
            mul_b = skip ? ONE_MW : MW'(f_rest);
        end else if ((r_state == ST_OSC) || (r_state == ST_QSC) || (r_state == ST_NSC)) begin
            mul_a = MW'(r_ref);
            mul_b = MW'(r_s);
        end else if (r_state == ST_LVL) begin
            mul_a = lvl;
            mul_b = MW'(f_rest);
        end
    end
    assign mul_p = mul_a * mul_b;

    // Restoring divider step
    assign want    = (SW+1)'(r_req.amount) << FRAC_BITS;
    assign div_bit = r_rem >= {1'b0, r_cap};
    assign rem_sub = div_bit ? (r_rem - {1'b0, r_cap}) : r_rem;

    assign f_sum     = (FW+1)'(f_rd) + (FW+1)'(r_q);
    assign ceil_sum  = (SW+1)'(r_sc) + ROUND_UP;
    assign nc_scaled = (SW+1)'(r_nc) << FRAC_BITS;
    assign old_ext   = (SW+1)'(r_old);
    assign diff      = old_ext - nc_scaled;
    assign out_free  = !r_out_valid || i_out_ready;

    // ------------------------------------------------------------------
    // Config registers and fraction store
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_cfg  <= mcst_pkg::REF_W'(1);
            r_axes_cfg <= mcst_pkg::AXES_CFG_W'(1);
            for (int i = 0; i < MAX_AXES; i++) begin
                r_frac[i] <= '0;
            end
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    mcst_pkg::REG_REF_POP: r_ref_cfg  <= pwdata[mcst_pkg::REF_W-1:0];
                    mcst_pkg::REG_AXES:    r_axes_cfg <= pwdata[mcst_pkg::AXES_CFG_W-1:0];
                    default:               ;
                endcase
            end
            if (r_state == ST_UPD) begin
                r_frac[axis_idx] <= (f_sum > (FW+1)'(ONE_FW)) ? ONE_FW : f_sum[FW-1:0];
            end else if (r_state == ST_LVL) begin
                // f + lvl*(1-f) never exceeds 1.0
                r_frac[axis_idx] <= f_rd + mul_p[FRAC_BITS +: FW];
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            // final step reloads the register itself
            if (r_out_valid && i_out_ready && (r_state != ST_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_state <= ST_SOLD;
                    end
                end
                ST_SOLD: begin
                    if (pass_done) begin
                        r_state <= ST_OSC;
                    end
                end
                ST_OSC: begin
                    // zero reference: old population is 0, nothing to update
                    if (r_err || (r_req.mode == mcst_pkg::MODE_REMOVE && r_ref == '0)) begin
                        r_state <= ST_CEIL;
                    end else if (r_req.mode == mcst_pkg::MODE_LEVEL) begin
                        r_state <= ST_LVL;
                    end else begin
                        r_state <= ST_QPASS;
                    end
                end
                ST_QPASS: begin
                    if (pass_done) begin
                        r_state <= ST_QSC;
                    end
                end
                ST_QSC: begin
                    // no survivors outside this cause, or none at all: no update
                    if (r_s == '0 || r_old == '0) begin
                        r_state <= ST_CEIL;
                    end else begin
                        r_state <= ST_DINIT;
                    end
                end
                ST_DINIT: r_state <= ST_DIV;
                ST_DIV: begin
                    if (r_dcnt == DCW'(FW - 1)) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD:  r_state <= ST_SNEW;
                ST_SNEW: begin
                    if (pass_done) begin
                        r_state <= ST_NSC;
                    end
                end
                ST_NSC:  r_state <= ST_CEIL;
                ST_CEIL: r_state <= ST_FIN;
                ST_FIN: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                ST_LVL: begin
                    r_state <= r_req.last_level ? ST_SNEW : ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Datapath registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_req  <= i_in_data;
                    r_ref  <= r_ref_cfg;
                    r_nact <= nact_in;
                    r_err  <= err_in;
                    r_s    <= ONE_FW;
                    r_cnt  <= '0;
                end
            end
            ST_SOLD, ST_QPASS, ST_SNEW: begin
                if (!pass_done) begin
                    r_s   <= mul_p[FRAC_BITS +: FW];
                    r_cnt <= r_cnt + CW'(1);
                end
            end
            ST_OSC: begin
                r_old <= mul_p[SW-1:0];
                r_sc  <= mul_p[SW-1:0];
                r_s   <= ONE_FW;
                r_cnt <= '0;
            end
            ST_QSC: begin
                r_cap <= mul_p[SW-1:0];
            end
            ST_DINIT: begin
                r_rem  <= (want > {1'b0, r_cap}) ? {1'b0, r_cap} : want;
                r_q    <= '0;
                r_dcnt <= '0;
            end
            ST_DIV: begin
                r_rem  <= rem_sub << 1;
                r_q    <= {r_q[FW-2:0], div_bit};
                r_dcnt <= r_dcnt + DCW'(1);
            end
            ST_UPD, ST_LVL: begin
                r_s   <= ONE_FW;
                r_cnt <= '0;
            end
            ST_NSC: begin
                r_sc <= mul_p[SW-1:0];
            end
            ST_CEIL: begin
                r_nc <= ceil_sum[SW:FRAC_BITS];
            end
            ST_FIN: begin
                if (out_free) begin
                    r_out.population <= r_nc[mcst_pkg::POP_W-1:0];
                    r_out.axis_error <= r_err;
                    if (r_req.mode == mcst_pkg::MODE_REMOVE && !r_err && old_ext >= nc_scaled) begin
                        r_out.removed <= diff[FRAC_BITS +: mcst_pkg::POP_W];
                    end else begin
                        r_out.removed <= '0;
                    end
                end
            end
            default: ;
        endcase
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // divider remainder stays below twice the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> (r_rem < ({1'b0, r_cap} << 1)))
        else $error("divider remainder out of range");

    // quotient never exceeds 1.0 since the request is clipped to the cap
    a_q_le_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_UPD) |-> (r_q <= ONE_FW))
        else $error("fraction increment above 1.0");

    // a flagged axis never reports a removal
    a_err_removed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.axis_error) |-> (o_out_data.removed == '0))
        else $error("removal reported on flagged axis");

    // a result only appears from the final sequencer step
    a_out_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_FIN))
        else $error("result raised outside final step");

endmodule
